// ----- hw/rtl/twsm_pkg.sv -----
// Shared constants for the three-wire serial master: phase codes, commands, sizes.
package twsm_pkg;

  // Sequencer phase codes
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_SETUP = 4'd1;
  localparam logic [3:0] PH_WDRV  = 4'd2;
  localparam logic [3:0] PH_WHI   = 4'd3;
  localparam logic [3:0] PH_WLO   = 4'd4;
  localparam logic [3:0] PH_RHI   = 4'd5;
  localparam logic [3:0] PH_RLO   = 4'd6;
  localparam logic [3:0] PH_RSMP  = 4'd7;
  localparam logic [3:0] PH_HOLD  = 4'd8;

  // Fixed burst command bytes
  localparam logic [7:0] CMD_BURST_READ  = 8'hBF;
  localparam logic [7:0] CMD_BURST_WRITE = 8'hBE;

  // Bytes moved by a burst
  localparam logic [3:0] BURST_BYTES = 4'd8;

  // Beat kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Register file
  localparam logic [7:0] SETUP_RESET = 8'd4;
  localparam logic [7:0] HOLD_RESET  = 8'd4;
  localparam logic       REG_SETUP   = 1'b0;
  localparam logic       REG_HOLD    = 1'b1;

endpackage

// ----- hw/rtl/three_wire_serial_master_unit.sv -----
// Three-wire serial master: phase sequencer, register port and result register.
//
//  Channel   | Direction | Handshake               | Payload
//  ----------+-----------+-------------------------+-------------------------------------
//  in        | sink      | in_valid_i / in_stall_o | kind, op, reg_address, write_data,
//            |           |                         | io_in
//  out       | source    | out_valid_o/out_stall_i | chip_enable, serial_clock, io_out,
//            |           |                         | io_drive, busy_res, done_res,
//            |           |                         | rejected, read_data
//  config    | APB slave | psel/penable/pready     | ce_setup_ticks @0, ce_hold_ticks @4
//
// One beat per clock unless in_stall_o holds it: each accepted beat updates the
// sequencer state and loads the result register in the same cycle, so the next
// beat follows immediately. out_valid_o rises in the cycle after an input accept.
// The single result register sets the rate; in_stall_o rises only while that
// register holds a result and the sink stalls it.
// Reset (rst_ni low, async) leaves the sequencer idle and setup/hold at 4 ticks.
module three_wire_serial_master_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  reg_address_i,
  input  logic [63:0] write_data_i,
  input  logic        io_in_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        chip_enable_o,
  output logic        serial_clock_o,
  output logic        io_out_o,
  output logic        io_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        rejected_o,
  output logic [63:0] read_data_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Register port: two 8-bit timing registers, word decoded on paddr[2]
  // ---------------------------------------------------------------------------
  logic [7:0] setup_q, hold_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= twsm_pkg::SETUP_RESET;
      hold_q  <= twsm_pkg::HOLD_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == twsm_pkg::REG_SETUP) setup_q <= pwdata[7:0];
      else                                 hold_q  <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      twsm_pkg::REG_SETUP: prdata = {24'd0, setup_q};
      twsm_pkg::REG_HOLD:  prdata = {24'd0, hold_q};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: one result register parts the two sides
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic in_acc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [3:0]  state_q, state_d;
  logic [2:0]  bit_q, bit_d;
  logic [3:0]  byte_q, byte_d;
  logic [1:0]  op_q, op_d;
  logic [63:0] tx_q, tx_d;
  logic [63:0] rx_q, rx_d;
  logic [7:0]  wait_q, wait_d;
  logic        done, rej;

  // helpers on current state
  logic       is_burst, is_read, cmd_const;
  logic [3:0] data_bytes, byte_inc;
  logic       last_bit, adv_finish;
  logic       do_adv;
  logic [3:0] adv_next;
  logic [5:0] rx_pos;
  logic       st_is_read;
  logic [7:0] st_cmd;

  assign is_burst   = op_q[1];
  assign is_read    = ~op_q[0];
  assign cmd_const  = (byte_q == 4'd0) && is_burst;
  assign data_bytes = is_burst ? twsm_pkg::BURST_BYTES : 4'd1;
  assign byte_inc   = byte_q + 4'd1;
  assign last_bit   = (bit_q == 3'd7);
  assign adv_finish = last_bit && (byte_inc > data_bytes);
  // read byte n lands in bits [8*(n-1) +: 8]
  assign rx_pos     = {3'(byte_q - 4'd1), bit_q};

  assign st_is_read = ~op_i[0];
  assign st_cmd     = {reg_address_i[7:1], st_is_read};

  always_comb begin
    state_d  = state_q;
    bit_d    = bit_q;
    byte_d   = byte_q;
    op_d     = op_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    wait_d   = wait_q;
    done     = 1'b0;
    rej      = 1'b0;
    do_adv   = 1'b0;
    adv_next = twsm_pkg::PH_IDLE;

    if (in_acc) begin
      if (kind_i == twsm_pkg::KIND_START) begin
        if (state_q != twsm_pkg::PH_IDLE) begin
          rej = 1'b1;
        end else begin
          op_d   = op_i;
          rx_d   = 64'd0;
          bit_d  = 3'd0;
          byte_d = 4'd0;
          if (op_i[1]) tx_d = st_is_read ? 64'd0 : write_data_i;
          else         tx_d = {48'd0, write_data_i[7:0], st_cmd};
          wait_d  = setup_q;
          state_d = twsm_pkg::PH_SETUP;
        end
      end else begin
        case (state_q)
          twsm_pkg::PH_IDLE: begin
          end
          twsm_pkg::PH_SETUP: begin
            if (wait_q > 8'd1) wait_d = wait_q - 8'd1;
            else               state_d = twsm_pkg::PH_WDRV;
          end
          twsm_pkg::PH_WDRV: begin
            state_d = twsm_pkg::PH_WHI;
          end
          twsm_pkg::PH_WHI: begin
            // last command bit of a read turns the line around
            if (byte_q == 4'd0 && is_read && last_bit) begin
              bit_d   = 3'd0;
              byte_d  = 4'd1;
              state_d = twsm_pkg::PH_RLO;
            end else begin
              state_d = twsm_pkg::PH_WLO;
            end
          end
          twsm_pkg::PH_WLO: begin
            if (!cmd_const) tx_d = {1'b0, tx_q[63:1]};
            do_adv   = 1'b1;
            adv_next = twsm_pkg::PH_WDRV;
          end
          twsm_pkg::PH_RHI: begin
            state_d = twsm_pkg::PH_RLO;
          end
          twsm_pkg::PH_RLO: begin
            state_d = twsm_pkg::PH_RSMP;
          end
          twsm_pkg::PH_RSMP: begin
            rx_d[rx_pos] = io_in_i;
            do_adv       = 1'b1;
            adv_next     = twsm_pkg::PH_RHI;
          end
          twsm_pkg::PH_HOLD: begin
            if (wait_q > 8'd1) begin
              wait_d = wait_q - 8'd1;
            end else begin
              state_d = twsm_pkg::PH_IDLE;
              done    = 1'b1;
            end
          end
          default: begin
            state_d = twsm_pkg::PH_IDLE;
          end
        endcase

        // bit/byte counter step shared by the write-low and sample phases
        if (do_adv) begin
          if (adv_finish) begin
            state_d = twsm_pkg::PH_HOLD;
            wait_d  = hold_q;
            bit_d   = 3'd0;
            byte_d  = 4'd0;
          end else if (last_bit) begin
            bit_d   = 3'd0;
            byte_d  = byte_inc;
            state_d = adv_next;
          end else begin
            bit_d   = bit_q + 3'd1;
            state_d = adv_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twsm_pkg::PH_IDLE;
      bit_q   <= 3'd0;
      byte_q  <= 4'd0;
      op_q    <= 2'd0;
      tx_q    <= 64'd0;
      rx_q    <= 64'd0;
      wait_q  <= 8'd0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      op_q    <= op_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      wait_q  <= wait_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pin levels from the next state
  // ---------------------------------------------------------------------------
  logic       pin_ce, pin_clk, pin_drv, pin_io, cur_bit, nx_const;
  logic [7:0] nx_cmd;

  assign nx_const = (byte_d == 4'd0) && op_d[1];
  assign nx_cmd   = op_d[0] ? twsm_pkg::CMD_BURST_WRITE : twsm_pkg::CMD_BURST_READ;
  assign cur_bit  = nx_const ? nx_cmd[bit_d] : tx_d[0];
  assign pin_ce   = (state_d >= twsm_pkg::PH_SETUP) && (state_d <= twsm_pkg::PH_RSMP);
  assign pin_clk  = (state_d == twsm_pkg::PH_WLO) || (state_d == twsm_pkg::PH_RLO);
  assign pin_drv  = (state_d >= twsm_pkg::PH_SETUP) && (state_d <= twsm_pkg::PH_WLO);
  assign pin_io   = pin_drv & cur_bit;

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= in_acc | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      chip_enable_o  <= pin_ce;
      serial_clock_o <= pin_clk;
      io_out_o       <= pin_io;
      io_drive_o     <= pin_drv;
      busy_res_o     <= (state_d != twsm_pkg::PH_IDLE);
      done_res_o     <= done;
      rejected_o     <= rej;
      read_data_o    <= rx_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twsm_pkg::PH_IDLE) |-> (bit_q == 3'd0 && byte_q == 4'd0))
    else $error("counters not cleared while idle");

  a_byte_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_q <= twsm_pkg::BURST_BYTES)
    else $error("byte counter beyond burst length");

  a_drive_needs_ce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && io_drive_o) |-> chip_enable_o)
    else $error("data line driven with chip enable low");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_res_o) |-> !busy_res_o)
    else $error("done pulse while still busy");

  a_reject_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == twsm_pkg::KIND_START && state_q != twsm_pkg::PH_IDLE)
      |=> (rejected_o && state_q == $past(state_q)))
    else $error("start during transaction not rejected");

endmodule

// ----- tb/tb_three_wire_serial_master_unit.sv -----
// Testbench for the three-wire serial master: directed table, random transfers, scoreboard.
`timescale 1ns / 1ps

module tb_three_wire_serial_master_unit;
  import twsm_pkg::*;

  // Operation codes carried on op_i
  localparam logic [1:0] OP_SINGLE_READ  = 2'd0;
  localparam logic [1:0] OP_SINGLE_WRITE = 2'd1;
  localparam logic [1:0] OP_BURST_READ   = 2'd2;
  localparam logic [1:0] OP_BURST_WRITE  = 2'd3;

  // Register byte addresses
  localparam logic [2:0] ADDR_SETUP = {REG_SETUP, 2'b00};
  localparam logic [2:0] ADDR_HOLD  = {REG_HOLD, 2'b00};

  localparam int SETTLE_CYCLES = 4;       // covers the result register, plus margin
  localparam int CYCLE_LIMIT   = 400000;  // timeout for the whole run
  localparam int PHASE_BEATS   = 110;     // minimum live beats per random config phase (the 255 phase uses 1)

  // One result beat, in port order
  typedef struct packed {
    logic        chip_enable;
    logic        serial_clock;
    logic        io_out;
    logic        io_drive;
    logic        busy;
    logic        done;
    logic        rejected;
    logic [63:0] read_data;
  } pin_beat_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic        kind;
    logic [1:0]  op;
    logic [7:0]  addr;
    logic [63:0] wdata;
    logic        io;
    logic        typed;
    logic        drain;
    pin_beat_t   want;
  } plan_row_t;

  localparam pin_beat_t PINS_QUIET = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        kind_i;
  logic [1:0]  op_i;
  logic [7:0]  reg_address_i;
  logic [63:0] write_data_i;
  logic        io_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        chip_enable_o;
  logic        serial_clock_o;
  logic        io_out_o;
  logic        io_drive_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic        rejected_o;
  logic [63:0] read_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  three_wire_serial_master_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .op_i          (op_i),
    .reg_address_i (reg_address_i),
    .write_data_i  (write_data_i),
    .io_in_i       (io_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .chip_enable_o (chip_enable_o),
    .serial_clock_o(serial_clock_o),
    .io_out_o      (io_out_o),
    .io_drive_o    (io_drive_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rejected_o    (rejected_o),
    .read_data_o   (read_data_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow sequencer: our own copy of the phase machine and register values.
  // Advanced once per accepted input beat, in the driver process.
  // ---------------------------------------------------------------------------
  logic [3:0]  seq_phase;
  logic [2:0]  seq_bit;
  logic [3:0]  seq_byte;   // 0 = command byte, 1.. = data bytes
  logic [1:0]  seq_op;
  logic [63:0] seq_tx;
  logic [63:0] seq_rx;
  logic [7:0]  seq_wait;
  logic [7:0]  cfg_setup;
  logic [7:0]  cfg_hold;

  pin_beat_t pending_pins[$];  // expected result beats, oldest first
  plan_row_t plan [14];

  int  mismatches;
  int  checked_beats;
  int  live_beats;       // beats that moved the sequencer or started a transfer
  int  rejected_starts;
  int  op_count [4];
  int  next_gap;         // idle cycles before the next input beat
  logic calm;            // stretch with no idling on either side
  pin_beat_t got;
  pin_beat_t want;

  // Burst commands send a fixed byte instead of the shift register
  function automatic logic cmd_fixed();
    return (seq_byte == 4'd0) && seq_op[1];
  endfunction

  // Next bit position; returns 1 once the last data bit has gone by
  function automatic logic bump_bit_position();
    logic [3:0] last_byte;
    last_byte = seq_op[1] ? BURST_BYTES : 4'd1;
    if (seq_bit == 3'd7) begin
      seq_bit  = 3'd0;
      seq_byte = seq_byte + 4'd1;
      if (seq_byte > last_byte) begin
        seq_phase = PH_HOLD;
        seq_wait  = cfg_hold;
        seq_byte  = 4'd0;
        return 1'b1;
      end
    end else begin
      seq_bit = seq_bit + 3'd1;
    end
    return 1'b0;
  endfunction

  // Apply one input beat to the shadow sequencer and return the pin levels
  function automatic pin_beat_t predict_pins(logic kind, logic [1:0] op, logic [7:0] addr,
                                             logic [63:0] wdata, logic io);
    pin_beat_t  r;
    logic       finished;
    logic [7:0] cmd;
    logic [7:0] burst_cmd;
    logic [2:0] slot;
    r = PINS_QUIET;
    finished = 1'b0;
    if (kind == KIND_START) begin
      if (seq_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        seq_op   = op;
        seq_rx   = 64'd0;
        seq_bit  = 3'd0;
        seq_byte = 4'd0;
        if (op[1]) begin
          seq_tx = op[0] ? wdata : 64'd0;
        end else begin
          // read forces address bit 0 high, write forces it low
          cmd    = {addr[7:1], ~op[0]};
          seq_tx = {48'd0, wdata[7:0], cmd};
        end
        seq_wait  = cfg_setup;
        seq_phase = PH_SETUP;
      end
    end else begin
      case (seq_phase)
        PH_SETUP: begin
          if (seq_wait > 8'd1) seq_wait = seq_wait - 8'd1;
          else seq_phase = PH_WDRV;
        end
        PH_WDRV: seq_phase = PH_WHI;
        PH_WHI: begin
          // last command bit of a read: the clock-high phase doubles as read bit 0
          if (seq_byte == 4'd0 && !seq_op[0] && seq_bit == 3'd7) begin
            seq_bit   = 3'd0;
            seq_byte  = 4'd1;
            seq_phase = PH_RLO;
          end else begin
            seq_phase = PH_WLO;
          end
        end
        PH_WLO: begin
          if (!cmd_fixed()) seq_tx = seq_tx >> 1;
          if (!bump_bit_position()) seq_phase = PH_WDRV;
        end
        PH_RHI: seq_phase = PH_RLO;
        PH_RLO: seq_phase = PH_RSMP;
        PH_RSMP: begin
          slot = seq_byte[2:0] - 3'd1;
          seq_rx[{slot, seq_bit}] = io;
          if (!bump_bit_position()) seq_phase = PH_RHI;
        end
        PH_HOLD: begin
          if (seq_wait > 8'd1) begin
            seq_wait = seq_wait - 8'd1;
          end else begin
            seq_phase = PH_IDLE;
            finished  = 1'b1;
          end
        end
        PH_IDLE: ;
        default: seq_phase = PH_IDLE;
      endcase
    end
    burst_cmd      = seq_op[0] ? CMD_BURST_WRITE : CMD_BURST_READ;
    r.chip_enable  = (seq_phase >= PH_SETUP) && (seq_phase <= PH_RSMP);
    r.serial_clock = (seq_phase == PH_WLO) || (seq_phase == PH_RLO);
    r.io_drive     = (seq_phase >= PH_SETUP) && (seq_phase <= PH_WLO);
    r.io_out       = r.io_drive ? (cmd_fixed() ? burst_cmd[seq_bit] : seq_tx[0]) : 1'b0;
    r.busy         = (seq_phase != PH_IDLE);
    r.done         = finished;
    r.read_data    = seq_rx;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout with %0d result beats still pending", pending_pins.size());
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input driver. Valid is only lowered when a gap follows, so a back-to-back
  // beat never sees valid dropped and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic kind, input logic [1:0] op, input logic [7:0] addr,
                           input logic [63:0] wdata, input logic io, input logic typed,
                           input pin_beat_t typed_pins);
    pin_beat_t guess;
    logic      ignored;
    repeat (next_gap) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    op_i          <= op;
    reg_address_i <= addr;
    write_data_i  <= wdata;
    io_in_i       <= io;
    do @(posedge clk_i); while (in_stall_o);
    // beat accepted at this edge
    ignored = (kind == KIND_TICK) ? (seq_phase == PH_IDLE) : (seq_phase != PH_IDLE);
    guess = predict_pins(kind, op, addr, wdata, io);
    if (!ignored) live_beats++;
    if (guess.rejected) rejected_starts++;
    pending_pins.push_back(typed ? typed_pins : guess);
    next_gap = calm ? 0 : $urandom_range(0, 10);
    if (next_gap > 0) in_valid_i <= 1'b0;
  endtask

  // Must be called in the step the last beat was accepted
  task automatic stop_input();
    if (next_gap == 0) in_valid_i <= 1'b0;
    next_gap = 1;
  endtask

  // Tick the sequencer back to idle, now and then throwing in a start that
  // must bounce (covers setup, shifting and hold time alike)
  task automatic drain_transfer();
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < 3)
        send_beat(KIND_START, 2'($urandom_range(0, 3)), 8'($urandom), {$urandom, $urandom},
                  1'($urandom), 1'b0, PINS_QUIET);
      else
        send_beat(KIND_TICK, 2'($urandom_range(0, 3)), 8'($urandom), {$urandom, $urandom},
                  1'($urandom), 1'b0, PINS_QUIET);
    end
  endtask

  // One complete transfer with random content, sometimes followed by a stray tick
  task automatic run_transfer();
    logic [1:0] op;
    op   = 2'($urandom_range(0, 3));
    calm = ($urandom_range(0, 4) == 0);
    op_count[op]++;
    send_beat(KIND_START, op, 8'($urandom), {$urandom, $urandom}, 1'($urandom), 1'b0,
              PINS_QUIET);
    drain_transfer();
    if ($urandom_range(0, 3) == 0)
      send_beat(KIND_TICK, op, 8'($urandom), {$urandom, $urandom}, 1'($urandom), 1'b0,
                PINS_QUIET);
  endtask

  task automatic wait_drained();
    while (pending_pins.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB: setup cycle, then access cycle until pready
  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rd);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write both timing registers, read them back, update the shadow copy
  task automatic set_timing(input logic [7:0] setup_v, input logic [7:0] hold_v);
    logic [31:0] rd;
    cfg_access(1'b1, ADDR_SETUP, {24'd0, setup_v}, rd);
    cfg_access(1'b1, ADDR_HOLD, {24'd0, hold_v}, rd);
    cfg_setup = setup_v;
    cfg_hold  = hold_v;
    cfg_access(1'b0, ADDR_SETUP, 32'd0, rd);
    if (rd !== {24'd0, setup_v})
      flag_mismatch($sformatf("setup register read %h, wrote %h", rd, setup_v));
    cfg_access(1'b0, ADDR_HOLD, 32'd0, rd);
    if (rd !== {24'd0, hold_v})
      flag_mismatch($sformatf("hold register read %h, wrote %h", rd, hold_v));
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per beat, scoreboard on every accepted beat
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      n = calm ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{chip_enable_o, serial_clock_o, io_out_o, io_drive_o, busy_res_o, done_res_o,
              rejected_o, read_data_o};
      if (pending_pins.size() == 0) begin
        flag_mismatch("result beat with nothing pending");
      end else begin
        want = pending_pins.pop_front();
        checked_beats++;
        if (got !== want)
          flag_mismatch($sformatf({"beat %0d ce %b/%b sclk %b/%b io %b/%b drv %b/%b ",
                                   "busy %b/%b done %b/%b rej %b/%b rd %h/%h (exp/act)"},
                                  checked_beats, want.chip_enable, got.chip_enable,
                                  want.serial_clock, got.serial_clock, want.io_out, got.io_out,
                                  want.io_drive, got.io_drive, want.busy, got.busy,
                                  want.done, got.done, want.rejected, got.rejected,
                                  want.read_data, got.read_data));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] setup_v;
    logic [7:0] hold_v;
    int         target;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_TICK;
    op_i          <= OP_SINGLE_READ;
    reg_address_i <= 8'd0;
    write_data_i  <= 64'd0;
    io_in_i       <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= 3'd0;
    pwdata        <= 32'd0;
    next_gap  = 1;
    calm      = 1'b0;
    cfg_setup = SETUP_RESET;
    cfg_hold  = HOLD_RESET;
    seq_phase = PH_IDLE;
    seq_bit   = 3'd0;
    seq_byte  = 4'd0;
    seq_op    = 2'd0;
    seq_tx    = 64'd0;
    seq_rx    = 64'd0;
    seq_wait  = 8'd0;

    // Directed table. Typed rows: idle ticks are all zero; a fresh start raises
    // enable and drive and shows bit 0 of the command; a start while busy bounces.
    //        kind        op               addr   wdata           io    typ   drain
    plan[0]  = '{KIND_TICK,  OP_SINGLE_READ,  8'h00, 64'd0,  1'b0, 1'b1, 1'b0, PINS_QUIET};
    plan[1]  = '{KIND_START, OP_SINGLE_READ,  8'h00, '1,     1'b0, 1'b1, 1'b0,
                 pin_beat_t'{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0}};
    plan[2]  = '{KIND_START, OP_BURST_WRITE,  8'hFF, '1,     1'b1, 1'b1, 1'b0,
                 pin_beat_t'{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 64'd0}};
    // walk the setup ticks into the first command bit
    plan[3]  = '{KIND_TICK,  OP_SINGLE_READ,  8'h00, 64'd0,  1'b1, 1'b0, 1'b0, PINS_QUIET};
    plan[4]  = '{KIND_TICK,  OP_SINGLE_READ,  8'h00, 64'd0,  1'b0, 1'b0, 1'b0, PINS_QUIET};
    plan[5]  = '{KIND_TICK,  OP_SINGLE_READ,  8'h00, 64'd0,  1'b1, 1'b0, 1'b0, PINS_QUIET};
    plan[6]  = '{KIND_TICK,  OP_SINGLE_READ,  8'h00, 64'd0,  1'b0, 1'b0, 1'b0, PINS_QUIET};
    plan[7]  = '{KIND_TICK,  OP_SINGLE_READ,  8'h00, 64'd0,  1'b1, 1'b0, 1'b0, PINS_QUIET};
    plan[8]  = '{KIND_TICK,  OP_SINGLE_READ,  8'h00, 64'd0,  1'b0, 1'b0, 1'b1, PINS_QUIET};
    // write with address 0xFF: bit 0 is forced low
    plan[9]  = '{KIND_START, OP_SINGLE_WRITE, 8'hFF, '1,     1'b1, 1'b1, 1'b1,
                 pin_beat_t'{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0}};
    // burst commands ignore the address: 0xBF starts with 1, 0xBE with 0
    plan[10] = '{KIND_START, OP_BURST_READ,   8'h54, 64'd0,  1'b0, 1'b1, 1'b1,
                 pin_beat_t'{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0}};
    plan[11] = '{KIND_START, OP_BURST_WRITE,  8'hAB, '1,     1'b1, 1'b1, 1'b1,
                 pin_beat_t'{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0}};
    // a burst write leaves read data cleared
    plan[12] = '{KIND_TICK,  OP_BURST_WRITE,  8'hFF, '1,     1'b1, 1'b1, 1'b0, PINS_QUIET};
    plan[13] = '{KIND_START, OP_SINGLE_READ,  8'h7E, 64'h5A, 1'b0, 1'b0, 1'b1, PINS_QUIET};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_beat(plan[i].kind, plan[i].op, plan[i].addr, plan[i].wdata, plan[i].io,
                plan[i].typed, plan[i].want);
      if (plan[i].drain) drain_transfer();
    end
    stop_input();
    wait_drained();

    // Random transfers over several timing settings, extremes included.
    // Zero acts as a single tick; the 255 phase runs just one transfer.
    live_beats = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       begin setup_v = 8'd1;   hold_v = 8'd1;   end
        1:       begin setup_v = 8'd255; hold_v = 8'd255; end
        2:       begin setup_v = 8'd0;   hold_v = 8'd0;   end
        3:       begin setup_v = 8'($urandom_range(2, 12)); hold_v = 8'($urandom_range(2, 12)); end
        default: begin setup_v = 8'd2;   hold_v = 8'd7;   end
      endcase
      set_timing(setup_v, hold_v);
      target = live_beats + ((ph == 1) ? 1 : PHASE_BEATS);
      while (live_beats < target) run_transfer();
      calm = 1'b0;
      stop_input();
      wait_drained();
    end

    $display("random transfers: %0d single read, %0d single write, %0d burst read, %0d burst write",
             op_count[OP_SINGLE_READ], op_count[OP_SINGLE_WRITE], op_count[OP_BURST_READ],
             op_count[OP_BURST_WRITE]);
    $display("%0d result beats checked, %0d starts bounced while busy, %0d mismatches",
             checked_beats, rejected_starts, mismatches);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/twsm_pkg.sv
hw/rtl/three_wire_serial_master_unit.sv
tb/tb_three_wire_serial_master_unit.sv
